>>> design/grayscale_packed_buffer_streamer_unit_defines.svh
// Assertion macros used by the checker file of the block.
`ifndef GRAYSCALE_PACKED_BUFFER_STREAMER_UNIT_DEFINES_SVH
`define GRAYSCALE_PACKED_BUFFER_STREAMER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GPBS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gpbs assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GPBS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gpbs assertion failed");

`endif

>>> design/gpbs_pkg.sv
`default_nettype none

package gpbs_pkg;

	localparam int CHIP_COUNT     = 2;
	localparam int CH_PER_CHIP    = 16;
	localparam int BYTES_PER_CHIP = 24;
	localparam int STORE_BYTES    = 48;
	localparam int FRAME_LEN      = CHIP_COUNT * BYTES_PER_CHIP;
	localparam int CHANNELS       = CHIP_COUNT * CH_PER_CHIP;
	localparam int ADDR_W         = $clog2(STORE_BYTES);
	localparam int CNT_W          = $clog2(FRAME_LEN + 1);
	localparam int MODE_W         = 2;
	localparam int CH_W           = 5;
	localparam int LVL_W          = 12;

	localparam logic [MODE_W-1:0] MODE_SET    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_STREAM = 2'd2;
	localparam logic [MODE_W-1:0] MODE_EVENT  = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE = 3'd0,
		S_SET0 = 3'd1,
		S_SET1 = 3'd2,
		S_CLR  = 3'd3,
		S_STR0 = 3'd4,
		S_STR1 = 3'd5,
		S_EVT  = 3'd6,
		S_STR2 = 3'd7
	} step_t;

	typedef enum logic [2:0] {
		COND_NONE,
		COND_CH_BAD,
		COND_PENDING,
		COND_NO_FIRE,
		COND_MORE
	} cond_t;

	typedef struct packed {
		logic wr_full;
		logic wr_merge;
		logic rd_frame;
		logic rd_merge;
		logic cnt_clr;
		logic cnt_inc;
		logic clr_frame;
		logic emit_byte;
		logic emit_latch;
		logic set_pend;
		logic clr_pend;
	} act_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		logic  skip;
		logic  dispatch;
		step_t jmp;
		step_t nxt;
	} ucode_t;

	typedef struct packed {
		logic ch_bad;
		logic pending;
		logic no_fire;
		logic more;
	} status_t;

	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t w;
		w = '0;
		w.cond = COND_NONE;
		w.jmp  = S_IDLE;
		w.nxt  = S_IDLE;
		unique case (step)
			S_IDLE: begin
				w.dispatch    = 1'b1;
				w.act.cnt_clr = 1'b1;
			end
			S_SET0: begin
				w.cond         = COND_CH_BAD;
				w.skip         = 1'b1;
				w.act.wr_full  = 1'b1;
				w.act.rd_merge = 1'b1;
				w.nxt          = S_SET1;
			end
			S_SET1: begin
				w.act.wr_merge = 1'b1;
			end
			S_CLR: begin
				w.act.clr_frame = 1'b1;
			end
			S_STR0: begin
				w.cond         = COND_PENDING;
				w.skip         = 1'b1;
				w.act.rd_frame = 1'b1;
				w.act.cnt_inc  = 1'b1;
				w.nxt          = S_STR1;
			end
			S_STR1: begin
				w.cond          = COND_MORE;
				w.jmp           = S_STR1;
				w.act.rd_frame  = 1'b1;
				w.act.cnt_inc   = 1'b1;
				w.act.emit_byte = 1'b1;
				w.nxt           = S_STR2;
			end
			S_STR2: begin
				w.act.set_pend = 1'b1;
			end
			S_EVT: begin
				w.cond           = COND_NO_FIRE;
				w.skip           = 1'b1;
				w.act.emit_latch = 1'b1;
				w.act.clr_pend   = 1'b1;
			end
			default: begin
				w.nxt = S_IDLE;
			end
		endcase
		return w;
	endfunction

	function automatic step_t entry_step(input logic [MODE_W-1:0] mode);
		step_t s;
		s = S_IDLE;
		unique case (mode)
			MODE_SET:    s = S_SET0;
			MODE_CLEAR:  s = S_CLR;
			MODE_STREAM: s = S_STR0;
			MODE_EVENT:  s = S_EVT;
			default:     s = S_IDLE;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

>>> design/gpbs_frame_mem.sv
`default_nettype none

module gpbs_frame_mem
	import gpbs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              clr,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [7:0]        wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [7:0]        rdata
);

	logic [7:0]             mem [STORE_BYTES];
	logic [STORE_BYTES-1:0] valid_q;
	logic                   rd_ok;
	logic                   wr_ok;

	assign rd_ok = re && ({1'b0, raddr} < (ADDR_W + 1)'(STORE_BYTES));
	assign wr_ok = we && ({1'b0, waddr} < (ADDR_W + 1)'(STORE_BYTES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clr) begin
			valid_q <= '0;
		end else if (wr_ok) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_ok) begin
			rdata <= valid_q[raddr] ? mem[raddr] : 8'h00;
		end
	end

endmodule

`default_nettype wire

>>> design/gpbs_sequencer.sv
`default_nettype none

module gpbs_sequencer
	import gpbs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [MODE_W-1:0] mode,
	input  wire status_t           status,
	output act_t                   act,
	output logic                   busy
);

	step_t  step_q;
	step_t  step_d;
	ucode_t word;
	logic   taken;

	assign word = ucode_rom(step_q);
	assign busy = (step_q != S_IDLE);

	always_comb begin
		unique case (word.cond)
			COND_NONE:    taken = 1'b0;
			COND_CH_BAD:  taken = status.ch_bad;
			COND_PENDING: taken = status.pending;
			COND_NO_FIRE: taken = status.no_fire;
			COND_MORE:    taken = status.more;
			default:      taken = 1'b0;
		endcase
	end

	always_comb begin
		act = (word.skip && taken) ? '0 : word.act;
		if (word.dispatch) begin
			step_d = start ? entry_step(mode) : S_IDLE;
		end else if (taken) begin
			step_d = word.jmp;
		end else begin
			step_d = word.nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

`default_nettype wire

>>> design/grayscale_packed_buffer_streamer_unit.sv
// Channel   | Ports                                   | Transaction
// ----------+-----------------------------------------+-------------------------------
// command   | start, busy, mode, channel, level,      | start high while busy is low
//           | counting_down                           |
// result    | strobe, kind, data_byte, last           | strobe high for one cycle
//
// A set passes through S_SET0 and S_SET1, a clear through S_CLR and a timer event through S_EVT.
// A stream passes through S_STR0, repeats S_STR1 until the whole frame is read, then S_STR2,
// and puts out one byte per cycle; the frame memory's one read port sets this pace.
// An ignored stream, set or event returns to idle from its first step with no action.
// After reset the frame reads as zero at once through per-byte valid flags.
// Results cannot be stalled, so nothing waits on the receiver.
`default_nettype none

module grayscale_packed_buffer_streamer_unit
	import gpbs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [MODE_W-1:0] mode,
	input  wire logic [CH_W-1:0]   channel,
	input  wire logic [LVL_W-1:0]  level,
	input  wire logic              counting_down,
	output logic                   strobe,
	output logic                   kind,
	output logic      [7:0]        data_byte,
	output logic                   last
);

	act_t              act;
	status_t           status;
	logic [CH_W-1:0]   ch_q;
	logic [LVL_W-1:0]  level_q;
	logic              down_q;
	logic              pend_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CH_W-1:0]   slot;
	logic [CH_W+1:0]   slot3;
	logic [ADDR_W-1:0] pos;
	logic [ADDR_W-1:0] pos1;
	logic [ADDR_W-1:0] full_addr;
	logic [ADDR_W-1:0] merge_addr;
	logic [7:0]        full_data;
	logic [7:0]        merge_data;
	logic [7:0]        rdata;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [7:0]        mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic              accept;

	assign accept = start && !busy;

	assign status.ch_bad  = ({1'b0, ch_q} >= (CH_W + 1)'(CHANNELS));
	assign status.pending = pend_q;
	assign status.no_fire = !(down_q && pend_q);
	assign status.more    = (cnt_q != CNT_W'(FRAME_LEN));

	// Levels sit in reverse channel order, two per three bytes.
	assign slot       = CH_W'(CHANNELS - 1) - ch_q;
	assign slot3      = {1'b0, slot, 1'b0} + {2'b00, slot};
	assign pos        = ADDR_W'(slot3[CH_W+1:1]);
	assign pos1       = pos + ADDR_W'(1);
	assign full_addr  = slot[0] ? pos1 : pos;
	assign merge_addr = slot[0] ? pos : pos1;
	assign full_data  = slot[0] ? level_q[7:0] : level_q[11:4];
	assign merge_data = slot[0] ? {rdata[7:4], level_q[11:8]} : {level_q[3:0], rdata[3:0]};

	assign mem_we    = act.wr_full || act.wr_merge;
	assign mem_waddr = act.wr_merge ? merge_addr : full_addr;
	assign mem_wdata = act.wr_merge ? merge_data : full_data;
	assign mem_re    = act.rd_frame || act.rd_merge;
	assign mem_raddr = act.rd_merge ? merge_addr : ADDR_W'(cnt_q);

	gpbs_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.status (status),
		.act    (act),
		.busy   (busy)
	);

	gpbs_frame_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (act.clr_frame),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.re     (mem_re),
		.raddr  (mem_raddr),
		.rdata  (rdata)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q    <= channel;
			level_q <= level;
			down_q  <= counting_down;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			cnt_q  <= '0;
			strobe <= 1'b0;
		end else begin
			if (act.set_pend) begin
				pend_q <= 1'b1;
			end else if (act.clr_pend) begin
				pend_q <= 1'b0;
			end
			if (act.cnt_clr) begin
				cnt_q <= '0;
			end else if (act.cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			strobe <= act.emit_byte || act.emit_latch;
		end
	end

	always_ff @(posedge clk) begin
		if (act.emit_latch) begin
			kind      <= 1'b1;
			data_byte <= 8'h00;
			last      <= 1'b1;
		end else if (act.emit_byte) begin
			kind      <= 1'b0;
			data_byte <= rdata;
			last      <= !status.more;
		end
	end

endmodule

`default_nettype wire

>>> design/gpbs_checker.sv
`default_nettype none
`include "grayscale_packed_buffer_streamer_unit_defines.svh"

module gpbs_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       strobe,
	input wire logic       kind,
	input wire logic [7:0] data_byte,
	input wire logic       last
);

	// A latch pulse is always a lone, final result with a zero data byte.
	`GPBS_ASSERT_SAME(a_latch_form, strobe && kind, last && (data_byte == 8'h00))

	// An accepted transaction always makes busy high in the cycle after it is accepted.
	`GPBS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

	// Bytes of one stream come in consecutive cycles until the last one.
	`GPBS_ASSERT_NEXT(a_stream_gapless, strobe && !kind && !last, strobe && !kind)

	// The final result of a run is never directly followed by another result.
	`GPBS_ASSERT_NEXT(a_gap_after_last, strobe && last, !strobe)

endmodule

bind grayscale_packed_buffer_streamer_unit gpbs_checker u_gpbs_checker (.*);

`default_nettype wire

>>> tb/sv/grayscale_packed_buffer_streamer_unit_tb.sv
`timescale 1ns / 100ps

module grayscale_packed_buffer_streamer_unit_tb;
	import gpbs_pkg::*;

	localparam logic KIND_BYTE  = 1'b0;
	localparam logic KIND_LATCH = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
		logic       last;
	} frame_result_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [MODE_W-1:0] mode;
	logic [CH_W-1:0]   channel;
	logic [LVL_W-1:0]  level;
	logic              counting_down;
	logic              strobe;
	logic              kind;
	logic [7:0]        data_byte;
	logic              last;

	logic [7:0]    frame_copy [STORE_BYTES];
	logic          latch_armed;
	frame_result_t awaited_results [$];
	frame_result_t oldest_result;

	int fail_count;
	int commands_sent;
	int bytes_checked;
	int latches_checked;
	int sender_idle_pct;

	grayscale_packed_buffer_streamer_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.mode          (mode),
		.channel       (channel),
		.level         (level),
		.counting_down (counting_down),
		.strobe        (strobe),
		.kind          (kind),
		.data_byte     (data_byte),
		.last          (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("Run timed out at %0t.", $time);
		$display("grayscale_packed_buffer_streamer_unit test failed");
		$finish;
	end

	function automatic int frame_length();
		return (FRAME_LEN > STORE_BYTES) ? STORE_BYTES : FRAME_LEN;
	endfunction

	task automatic store_level(input logic [CH_W-1:0] ch, input logic [LVL_W-1:0] lv);
		int slot;
		int pos;
		if (int'(ch) >= CHANNELS)
			return;
		slot = CHANNELS - 1 - int'(ch);
		pos  = (slot * 3) >> 1;
		if (pos + 1 >= frame_length())
			return;
		if (slot % 2 == 1) begin
			frame_copy[pos]     = {frame_copy[pos][7:4], lv[11:8]};
			frame_copy[pos + 1] = lv[7:0];
		end else begin
			frame_copy[pos]     = lv[11:4];
			frame_copy[pos + 1] = {lv[3:0], frame_copy[pos + 1][3:0]};
		end
	endtask

	task automatic predict_command(input logic [MODE_W-1:0] m, input logic [CH_W-1:0] ch,
			input logic [LVL_W-1:0] lv, input logic dn);
		int n;
		n = frame_length();
		case (m)
			MODE_SET: begin
				store_level(ch, lv);
			end
			MODE_CLEAR: begin
				foreach (frame_copy[i])
					frame_copy[i] = 8'h00;
			end
			MODE_STREAM: begin
				if (!latch_armed) begin
					for (int i = 0; i < n; i++)
						awaited_results.push_back({KIND_BYTE, frame_copy[i], i == n - 1});
					latch_armed = 1'b1;
				end
			end
			default: begin
				if (dn && latch_armed) begin
					awaited_results.push_back({KIND_LATCH, 8'h00, 1'b1});
					latch_armed = 1'b0;
				end
			end
		endcase
	endtask

	// Idle fields carry junk so that the block is seen to ignore them while start is low.
	task automatic send_command(input logic [MODE_W-1:0] m, input logic [CH_W-1:0] ch,
			input logic [LVL_W-1:0] lv, input logic dn);
		int gap;
		gap = 0;
		if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
			gap = ($urandom_range(7) == 0) ? $urandom_range(7, 60) : $urandom_range(1, 6);
		if (gap > 0) begin
			start         <= 1'b0;
			mode          <= MODE_W'($urandom_range(3));
			channel       <= CH_W'($urandom_range(31));
			level         <= LVL_W'($urandom_range(4095));
			counting_down <= 1'($urandom_range(1));
			repeat (gap) @(posedge clk);
		end
		start         <= 1'b1;
		mode          <= m;
		channel       <= ch;
		level         <= lv;
		counting_down <= dn;
		do @(posedge clk); while (busy);
		predict_command(m, ch, lv, dn);
		commands_sent++;
	endtask

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result: kind %0d data_byte 0x%02h last %0d",
					$time, kind, data_byte, last);
				fail_count++;
			end else begin
				oldest_result = awaited_results.pop_front();
				if (kind !== oldest_result.kind) begin
					$display("%0t: kind expected %0d actual %0d",
						$time, oldest_result.kind, kind);
					fail_count++;
				end
				if (data_byte !== oldest_result.data_byte) begin
					$display("%0t: data_byte expected 0x%02h actual 0x%02h",
						$time, oldest_result.data_byte, data_byte);
					fail_count++;
				end
				if (last !== oldest_result.last) begin
					$display("%0t: last expected %0d actual %0d",
						$time, oldest_result.last, last);
					fail_count++;
				end
				if (oldest_result.kind == KIND_LATCH)
					latches_checked++;
				else
					bytes_checked++;
			end
		end
	end

	task automatic test_frame_after_reset();
		send_command(MODE_STREAM, 5'd0, 12'h000, 1'b0);
		send_command(MODE_EVENT, 5'd0, 12'h000, 1'b1);
	endtask

	task automatic test_level_packing();
		send_command(MODE_SET, 5'd31, 12'hFFF, 1'b0);
		send_command(MODE_SET, 5'd30, 12'hABC, 1'b1);
		send_command(MODE_SET, 5'd0, 12'h5A3, 1'b0);
		send_command(MODE_SET, 5'd1, 12'h000, 1'b1);
		send_command(MODE_SET, 5'd16, 12'h800, 1'b0);
		send_command(MODE_SET, 5'd15, 12'h001, 1'b1);
		send_command(MODE_STREAM, 5'd31, 12'hFFF, 1'b1);
		send_command(MODE_EVENT, 5'd0, 12'h000, 1'b1);
	endtask

	task automatic test_latch_pending_rules();
		send_command(MODE_STREAM, 5'd0, 12'h000, 1'b0);
		send_command(MODE_STREAM, 5'd0, 12'h000, 1'b0);
		send_command(MODE_EVENT, 5'd0, 12'h000, 1'b0);
		send_command(MODE_SET, 5'd5, 12'h123, 1'b0);
		send_command(MODE_CLEAR, 5'd31, 12'hFFF, 1'b1);
		send_command(MODE_STREAM, 5'd0, 12'h000, 1'b0);
		send_command(MODE_EVENT, 5'd0, 12'h000, 1'b1);
		send_command(MODE_EVENT, 5'd0, 12'h000, 1'b1);
		send_command(MODE_STREAM, 5'd0, 12'h000, 1'b0);
		send_command(MODE_EVENT, 5'd0, 12'h000, 1'b1);
	endtask

	// Mostly whole update cycles: a few sets, a stream, then compare events to fire the latch.
	task automatic test_random_traffic(input int idle_pct, input int item_goal);
		int first_count;
		int n_sets;
		sender_idle_pct = idle_pct;
		first_count     = commands_sent;
		while (commands_sent - first_count < item_goal) begin
			if ($urandom_range(99) < 80) begin
				n_sets = $urandom_range(0, 6);
				repeat (n_sets)
					send_command(MODE_SET, CH_W'($urandom_range(31)),
						LVL_W'($urandom_range(4095)), 1'($urandom_range(1)));
				if ($urandom_range(9) == 0)
					send_command(MODE_CLEAR, CH_W'($urandom_range(31)),
						LVL_W'($urandom_range(4095)), 1'($urandom_range(1)));
				send_command(MODE_STREAM, CH_W'($urandom_range(31)),
					LVL_W'($urandom_range(4095)), 1'($urandom_range(1)));
				if ($urandom_range(3) == 0)
					send_command(MODE_EVENT, CH_W'($urandom_range(31)),
						LVL_W'($urandom_range(4095)), 1'b0);
				send_command(MODE_EVENT, CH_W'($urandom_range(31)),
					LVL_W'($urandom_range(4095)), $urandom_range(9) != 0);
			end else begin
				send_command(MODE_W'($urandom_range(3)), CH_W'($urandom_range(31)),
					LVL_W'($urandom_range(4095)), 1'($urandom_range(1)));
			end
		end
	endtask

	initial begin
		int waited;
		fail_count      = 0;
		commands_sent   = 0;
		bytes_checked   = 0;
		latches_checked = 0;
		sender_idle_pct = 0;
		latch_armed     = 1'b0;
		foreach (frame_copy[i])
			frame_copy[i] = 8'h00;
		arst_n        <= 1'b0;
		start         <= 1'b0;
		mode          <= MODE_SET;
		channel       <= '0;
		level         <= '0;
		counting_down <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_frame_after_reset();
		test_level_packing();
		test_latch_pending_rules();
		test_random_traffic(0, 32);
		test_random_traffic(65, 28);
		test_random_traffic(33, 28);

		start  <= 1'b0;
		waited = 0;
		while (awaited_results.size() != 0 && waited < 1000) begin
			@(posedge clk);
			waited++;
		end
		repeat (FRAME_LEN + 10) @(posedge clk);
		if (awaited_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, awaited_results.size());
			fail_count++;
		end

		$display("Ran %0d commands across three sender idling phases; checked %0d frame bytes",
			commands_sent, bytes_checked);
		$display("and %0d latch pulses, with %0d mismatches.", latches_checked, fail_count);
		if (fail_count == 0)
			$display("grayscale_packed_buffer_streamer_unit test passed");
		else
			$display("grayscale_packed_buffer_streamer_unit test failed");
		$finish;
	end

endmodule
